// File: rtl/assert_macros.svh
// Assertion macros used by the fade engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (rst) \
  (a) |-> (b)) else $error("same-cycle implication failed");
`define ASSERT_NEXT(lbl, a, b) lbl: assert property (@(posedge clk) disable iff (rst) \
  (a) |=> (b)) else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(lbl, a, b)
`define ASSERT_NEXT(lbl, a, b)
`endif
`endif

// File: rtl/lcfe_pkg.sv
// Types and constants of the LED color fade engine.
package lcfe_pkg;

  localparam logic [2:0] KIND_SET       = 3'd0;
  localparam logic [2:0] KIND_SET_ALL   = 3'd1;
  localparam logic [2:0] KIND_PULSE     = 3'd2;
  localparam logic [2:0] KIND_PULSE_ALL = 3'd3;
  localparam logic [2:0] KIND_CLEAR     = 3'd4;
  localparam logic [2:0] KIND_CLEAR_ALL = 3'd5;
  localparam logic [2:0] KIND_TICK      = 3'd6;

  localparam int TL_W  = 18;
  localparam int DIV_W = 18;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam logic [TL_W-1:0] PULSE_MS = 18'd100;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DIV,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  pixel;
    logic [23:0] color;
    logic [23:0] second_color;
    logic [15:0] fade_ms;
    logic [31:0] now_ms;
    logic [15:0] elapsed_ms;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  out_pixel;
    logic [23:0] out_color;
    logic        last_pixel;
  } res_t;

  typedef struct packed {
    logic [23:0]     cur;
    logic [23:0]     tgt;
    logic [TL_W-1:0] tl;
    logic [31:0]     bump;
    logic [23:0]     pf;
    logic [23:0]     ps;
    logic            act;
  } entry_t;

endpackage

// File: rtl/led_color_fade_engine.sv
// LED color fade engine top level: pixel state memory, command sequencer and serial divider.
// A command transfer is taken when start is high and busy is low; if the command has a known
// kind and, for a single-pixel kind, a pixel below PIXELS, busy then stays high until it is
// finished, else the command is dropped and busy stays low. Per-pixel state lives in one
// memory of PIXELS entries; each entry has a valid bit that reset clears, and an entry that
// is not valid reads as all zero, so there is no clearing pass after reset. Every command
// walks the pixels it touches with a read, evaluate and write back sequence per pixel (S_READ,
// S_EVAL, S_WRITE). A tick also runs each fading pixel through one shared restoring divider of
// 18 bits (state S_DIV, between evaluate and write back): one division for the time chunk and,
// unless the pixel steps slowly, one per color channel. A tick reports one result per pixel,
// in pixel order, marked by done for exactly one cycle each; last_pixel flags the final one.
// The receiver cannot stall these results, so it must take every done cycle.
`include "assert_macros.svh"

module led_color_fade_engine #(
  parameter int PIXELS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  lcfe_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done,
  output lcfe_pkg::res_t  result
);

  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int TL_W = lcfe_pkg::TL_W;
  localparam int DIV_W = lcfe_pkg::DIV_W;
  localparam int CNT_W = lcfe_pkg::CNT_W;

  lcfe_pkg::state_t state, state_next;
  lcfe_pkg::cmd_t   cmd_r;
  lcfe_pkg::entry_t mem [PIXELS];
  lcfe_pkg::entry_t rdata, ent, ev, work;
  logic             vld [PIXELS];
  logic             rvld;
  logic [AW-1:0]    idx;

  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] quo, divisor, chunk;
  logic [CNT_W-1:0] cnt;
  logic [1:0]       phase;
  logic [DIV_W:0]   rem_s;
  logic             rem_ge;

  logic             is_all, accept_ok, accept, need_div, slow_now, last_idx;
  logic             mem_we, emit;
  logic [31:0]      since;
  logic [7:0]       ch_c [3];
  logic [7:0]       ch_t [3];
  logic [7:0]       ch_mag [3];
  logic             ch_neg [3];
  logic [23:0]      slow_cur;
  logic [TL_W-1:0]  el_ext;

  function automatic logic is_all_r();
    return (cmd_r.kind == lcfe_pkg::KIND_SET_ALL) || (cmd_r.kind == lcfe_pkg::KIND_PULSE_ALL)
        || (cmd_r.kind == lcfe_pkg::KIND_CLEAR_ALL) || (cmd_r.kind == lcfe_pkg::KIND_TICK);
  endfunction

  // Command decode. A tick always covers every pixel.
  assign is_all = (cmd.kind == lcfe_pkg::KIND_SET_ALL) || (cmd.kind == lcfe_pkg::KIND_PULSE_ALL)
               || (cmd.kind == lcfe_pkg::KIND_CLEAR_ALL) || (cmd.kind == lcfe_pkg::KIND_TICK);
  assign accept_ok = is_all || ((cmd.kind == lcfe_pkg::KIND_SET) ||
                                (cmd.kind == lcfe_pkg::KIND_PULSE) ||
                                (cmd.kind == lcfe_pkg::KIND_CLEAR)) &&
                               (32'(cmd.pixel) < PIXELS);
  assign accept = start && !busy;
  assign last_idx = (idx == AW'(PIXELS - 1));
  assign el_ext = TL_W'(cmd_r.elapsed_ms);

  // Evaluate one entry: apply the command, or for a tick restart a finished pulse and
  // decide whether the pixel snaps, holds, or needs the divider.
  always_comb begin
    ent = rvld ? rdata : '0;
    ev = ent;
    need_div = 1'b0;
    unique case (cmd_r.kind)
      lcfe_pkg::KIND_SET, lcfe_pkg::KIND_SET_ALL: begin
        ev.tgt = cmd_r.color;
        ev.tl = TL_W'(cmd_r.fade_ms);
        ev.bump = cmd_r.now_ms;
      end
      lcfe_pkg::KIND_PULSE, lcfe_pkg::KIND_PULSE_ALL: begin
        ev.act = 1'b1;
        ev.tgt = cmd_r.color;
        ev.pf = cmd_r.color;
        ev.ps = cmd_r.second_color;
      end
      lcfe_pkg::KIND_CLEAR, lcfe_pkg::KIND_CLEAR_ALL: begin
        ev.tgt = '0;
        ev.tl = '0;
        ev.bump = cmd_r.now_ms;
        ev.act = 1'b0;
      end
      lcfe_pkg::KIND_TICK: begin
        if (ent.act && (ent.tl == '0)) begin
          ev.tgt = (ent.tgt == ent.pf) ? ent.ps : ent.pf;
          ev.tl = lcfe_pkg::PULSE_MS;
        end
        if (cmd_r.elapsed_ms != '0) begin
          if (ev.cur == ev.tgt) begin
            ev.tl = '0;
          end else if ((ev.tl == '0) || (el_ext > ev.tl)) begin
            ev.cur = ev.tgt;
            ev.tl = '0;
          end else begin
            need_div = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // One restoring division step.
  assign rem_s = {rem[DIV_W-1:0], quo[DIV_W-1]};
  assign rem_ge = (rem_s >= {1'b0, divisor});

  // Per-channel view of the entry under work, red first.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ch_c[j] = work.cur[23 - 8*j -: 8];
      ch_t[j] = work.tgt[23 - 8*j -: 8];
      ch_neg[j] = (ch_t[j] < ch_c[j]);
      ch_mag[j] = ch_neg[j] ? (ch_c[j] - ch_t[j]) : (ch_t[j] - ch_c[j]);
      if (ch_t[j] > ch_c[j]) begin
        slow_cur[23 - 8*j -: 8] = ch_c[j] + 8'd1;
      end else if (ch_t[j] < ch_c[j]) begin
        slow_cur[23 - 8*j -: 8] = ch_c[j] - 8'd1;
      end else begin
        slow_cur[23 - 8*j -: 8] = ch_c[j];
      end
    end
  end

  // A pixel is slow when the chunk exceeds the signed time since its last bump.
  assign since = cmd_r.now_ms - work.bump;
  assign slow_now = $signed({15'd0, quo}) > $signed({since[31], since});

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lcfe_pkg::S_IDLE: if (accept && accept_ok) state_next = lcfe_pkg::S_READ;
      lcfe_pkg::S_READ: state_next = lcfe_pkg::S_EVAL;
      lcfe_pkg::S_EVAL: state_next = need_div ? lcfe_pkg::S_DIV : lcfe_pkg::S_WRITE;
      lcfe_pkg::S_DIV: begin
        if ((cnt == '0) && ((phase == 2'd0) ? slow_now : (phase == 2'd3))) begin
          state_next = lcfe_pkg::S_WRITE;
        end
      end
      lcfe_pkg::S_WRITE: begin
        if (is_all_r() && !last_idx) state_next = lcfe_pkg::S_READ;
        else state_next = lcfe_pkg::S_IDLE;
      end
      default: state_next = lcfe_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    busy = (state != lcfe_pkg::S_IDLE);
    mem_we = (state == lcfe_pkg::S_WRITE);
    emit = mem_we && (cmd_r.kind == lcfe_pkg::KIND_TICK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcfe_pkg::S_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= emit;
    end
  end

  // State memory with a registered read.
  always_ff @(posedge clk) begin
    rdata <= mem[idx];
    if (mem_we) mem[idx] <= work;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIXELS; i++) vld[i] <= 1'b0;
      rvld <= 1'b0;
    end else begin
      rvld <= vld[idx];
      if (mem_we) vld[idx] <= 1'b1;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      lcfe_pkg::S_IDLE: begin
        if (accept) begin
          cmd_r <= cmd;
          idx <= is_all ? '0 : AW'(cmd.pixel);
        end
      end
      lcfe_pkg::S_READ: begin
      end
      lcfe_pkg::S_EVAL: begin
        work <= ev;
        rem <= '0;
        quo <= DIV_W'(ev.tl);
        divisor <= DIV_W'(el_ext);
        cnt <= CNT_W'(DIV_W);
        phase <= 2'd0;
      end
      lcfe_pkg::S_DIV: begin
        if (cnt != '0) begin
          rem <= rem_ge ? (rem_s - {1'b0, divisor}) : rem_s;
          quo <= {quo[DIV_W-2:0], rem_ge};
          cnt <= cnt - 1'b1;
        end else if (phase == 2'd0) begin
          chunk <= quo;
          if (slow_now) begin
            work.cur <= slow_cur;
            work.bump <= cmd_r.now_ms;
            work.tl <= work.tl - el_ext;
          end else begin
            rem <= '0;
            quo <= DIV_W'(ch_mag[0]);
            divisor <= quo;
            cnt <= CNT_W'(DIV_W);
            phase <= 2'd1;
          end
        end else begin
          // Channel phase-1 done: the quotient is at most 255.
          work.cur[23 - 8*(phase - 2'd1) -: 8] <= ch_neg[phase - 2'd1]
            ? (ch_c[phase - 2'd1] - quo[7:0]) : (ch_c[phase - 2'd1] + quo[7:0]);
          if (phase == 2'd3) begin
            work.tl <= work.tl - el_ext;
          end else begin
            rem <= '0;
            quo <= DIV_W'(ch_mag[phase]);
            divisor <= chunk;
            cnt <= CNT_W'(DIV_W);
            phase <= phase + 2'd1;
          end
        end
      end
      lcfe_pkg::S_WRITE: begin
        result.out_pixel <= 3'(idx);
        result.out_color <= work.cur;
        result.last_pixel <= last_idx;
        if (!last_idx) idx <= idx + 1'b1;
      end
      default: begin
      end
    endcase
  end

  `ASSERT_NEXT(a_emit_done, emit, done)
  `ASSERT_IMPLY(a_cnt_range, state == lcfe_pkg::S_DIV, cnt <= CNT_W'(DIV_W))
  `ASSERT_NEXT(a_accept_busy, accept && accept_ok, busy)

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the LED color fade engine.
`timescale 1ns / 100ps

module testbench;

  localparam int NPIX = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 800;
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  // The scoreboard keeps its own copy of every pixel's state and predicts
  // the colors that a tick reports.
  class fade_scoreboard;
    logic [23:0] cur [NPIX];
    logic [23:0] tgt [NPIX];
    logic [17:0] tl [NPIX];
    logic [31:0] bump [NPIX];
    logic [23:0] pf [NPIX];
    logic [23:0] ps [NPIX];
    bit act [NPIX];
    lcfe_pkg::res_t pending_colors[$];
    int errors;

    function new();
      for (int i = 0; i < NPIX; i++) begin
        cur[i] = '0; tgt[i] = '0; tl[i] = '0; bump[i] = '0;
        pf[i] = '0; ps[i] = '0; act[i] = 0;
      end
      errors = 0;
    endfunction

    function void set_px(int p, logic [23:0] c, logic [15:0] f, logic [31:0] now);
      tgt[p] = c;
      tl[p] = {2'b00, f};
      bump[p] = now;
    endfunction

    function void pulse_px(int p, logic [23:0] c1, logic [23:0] c2);
      act[p] = 1;
      tgt[p] = c1;
      pf[p] = c1;
      ps[p] = c2;
    endfunction

    // One fade step of one pixel; the slow case moves each channel by one.
    function void step_px(int p, logic [15:0] d, logic [31:0] now);
      int chunk, diff, stepv, c, t;
      longint since;
      bit slow;
      logic [23:0] res;
      if (cur[p] == tgt[p]) begin
        tl[p] = '0;
        return;
      end
      if (tl[p] == 0 || d > tl[p]) begin
        cur[p] = tgt[p];
        tl[p] = '0;
        return;
      end
      chunk = tl[p] / d;
      since = longint'($signed(now - bump[p]));
      slow = longint'(chunk) > since;
      res = '0;
      for (int sh = 16; sh >= 0; sh -= 8) begin
        c = (cur[p] >> sh) & 8'hFF;
        t = (tgt[p] >> sh) & 8'hFF;
        diff = t - c;
        if (slow) stepv = (diff > 0) ? 1 : (diff < 0) ? -1 : 0;
        else stepv = diff / chunk;
        res = res | (24'((c + stepv) & 8'hFF) << sh);
      end
      if (slow) bump[p] = now;
      cur[p] = res;
      tl[p] = tl[p] - 18'(d);
    endfunction

    // Notes an accepted command transfer and queues the colors it reports.
    function void note_command(lcfe_pkg::cmd_t c);
      lcfe_pkg::res_t r;
      case (c.kind)
        lcfe_pkg::KIND_SET: set_px(c.pixel, c.color, c.fade_ms, c.now_ms);
        lcfe_pkg::KIND_SET_ALL:
          for (int i = 0; i < NPIX; i++) set_px(i, c.color, c.fade_ms, c.now_ms);
        lcfe_pkg::KIND_PULSE: pulse_px(c.pixel, c.color, c.second_color);
        lcfe_pkg::KIND_PULSE_ALL:
          for (int i = 0; i < NPIX; i++) pulse_px(i, c.color, c.second_color);
        lcfe_pkg::KIND_CLEAR: begin
          set_px(c.pixel, '0, '0, c.now_ms);
          act[c.pixel] = 0;
        end
        lcfe_pkg::KIND_CLEAR_ALL: for (int i = 0; i < NPIX; i++) begin
          set_px(i, '0, '0, c.now_ms);
          act[i] = 0;
        end
        lcfe_pkg::KIND_TICK: begin
          // Finished pulses swap their target first, even without a step.
          for (int i = 0; i < NPIX; i++) begin
            if (act[i] && tl[i] == 0) begin
              tgt[i] = (tgt[i] == pf[i]) ? ps[i] : pf[i];
              tl[i] = lcfe_pkg::PULSE_MS;
            end
          end
          if (c.elapsed_ms != 0)
            for (int i = 0; i < NPIX; i++) step_px(i, c.elapsed_ms, c.now_ms);
          for (int i = 0; i < NPIX; i++) begin
            r.out_pixel = 3'(i);
            r.out_color = cur[i];
            r.last_pixel = (i == NPIX - 1);
            pending_colors.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_color(lcfe_pkg::res_t got);
      lcfe_pkg::res_t want;
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_colors.pop_front();
      if (got.out_pixel !== want.out_pixel) begin
        $display("%0t: out_pixel expected %0d actual %0d", $time, want.out_pixel,
                 got.out_pixel);
        errors++;
      end
      if (got.out_color !== want.out_color) begin
        $display("%0t: out_color expected %h actual %h", $time, want.out_color,
                 got.out_color);
        errors++;
      end
      if (got.last_pixel !== want.last_pixel) begin
        $display("%0t: last_pixel expected %b actual %b", $time, want.last_pixel,
                 got.last_pixel);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  lcfe_pkg::cmd_t cmd = '0;
  logic busy, done;
  lcfe_pkg::res_t result;

  fade_scoreboard board = new();
  int cycle_count = 0;
  logic [31:0] clock_ms = 0;
  int burst_left = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  led_color_fade_engine #(.PIXELS(NPIX)) dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .result(result)
  );

  // Results cannot be held off, so every done cycle is checked.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && done) board.check_color(result);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Issues one command and holds start until the transfer is taken. The sender
  // works in bursts, mostly with a random gap between bursts; start drops only in a gap.
  task automatic send_command(lcfe_pkg::cmd_t c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) begin
        start <= 0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_command(c);
  endtask

  function automatic lcfe_pkg::cmd_t make_cmd(logic [2:0] k);
    lcfe_pkg::cmd_t c;
    c.kind = k;
    c.pixel = 3'($urandom);
    c.color = 24'($urandom);
    c.second_color = 24'($urandom);
    c.fade_ms = 16'($urandom_range(0, 600));
    if ($urandom_range(0, 9) == 0) c.fade_ms = 16'($urandom);
    c.now_ms = clock_ms;
    c.elapsed_ms = 16'($urandom_range(0, 40));
    if ($urandom_range(0, 15) == 0) c.elapsed_ms = 16'($urandom);
    return c;
  endfunction

  // A tick advances the time stamp, sometimes by a random jump that may wrap it.
  task automatic send_tick(logic [15:0] el);
    lcfe_pkg::cmd_t c;
    c = make_cmd(lcfe_pkg::KIND_TICK);
    c.elapsed_ms = el;
    if ($urandom_range(0, 19) == 0) clock_ms = clock_ms + $urandom;
    else clock_ms = clock_ms + el;
    c.now_ms = clock_ms;
    send_command(c);
  endtask

  initial begin
    lcfe_pkg::cmd_t c;
    int pick;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part: field extremes, every kind, wrap of the time stamp.
    send_tick(16'd0);
    c = make_cmd(lcfe_pkg::KIND_SET); c.pixel = 3'd0; c.color = 24'hFFFFFF;
    c.fade_ms = 16'd0;
    send_command(c);
    c = make_cmd(lcfe_pkg::KIND_SET); c.pixel = 3'd7; c.color = 24'hFF00FF;
    c.fade_ms = 16'hFFFF;
    send_command(c);
    send_tick(16'd1);
    c = make_cmd(lcfe_pkg::KIND_SET_ALL); c.color = 24'h80FF01; c.fade_ms = 16'd300;
    send_command(c);
    send_tick(16'd10);
    send_tick(16'hFFFF);
    c = make_cmd(lcfe_pkg::KIND_PULSE); c.pixel = 3'd3; c.color = 24'h000000;
    c.second_color = 24'hFFFFFF; send_command(c);
    c = make_cmd(lcfe_pkg::KIND_PULSE_ALL); c.color = 24'h123456;
    c.second_color = 24'hFEDCBA;
    send_command(c);
    send_tick(16'd0);
    send_tick(16'd50);
    send_tick(16'd60);
    c = make_cmd(lcfe_pkg::KIND_CLEAR); c.pixel = 3'd5; send_command(c);
    c = make_cmd(lcfe_pkg::KIND_CLEAR_ALL); send_command(c);
    c = make_cmd(KIND_UNUSED); send_command(c);
    clock_ms = 32'hFFFF_FFF0;
    c = make_cmd(lcfe_pkg::KIND_SET_ALL); c.color = 24'h00FF00; c.fade_ms = 16'd200;
    send_command(c);
    send_tick(16'd30);
    send_tick(16'd30);

    // Random part, weighted toward ticks so that fades and pulses progress.
    for (int n = 0; n < 100; n++) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) send_tick(16'($urandom_range(0, 40)) |
                               (($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'd0));
      else if (pick < 13) send_command(make_cmd(lcfe_pkg::KIND_SET));
      else if (pick < 14) send_command(make_cmd(lcfe_pkg::KIND_SET_ALL));
      else if (pick < 16) send_command(make_cmd(lcfe_pkg::KIND_PULSE));
      else if (pick < 17) send_command(make_cmd(lcfe_pkg::KIND_PULSE_ALL));
      else if (pick < 18) send_command(make_cmd(lcfe_pkg::KIND_CLEAR));
      else if (pick < 19) send_command(make_cmd(lcfe_pkg::KIND_CLEAR_ALL));
      else send_command(make_cmd(KIND_UNUSED));
    end
    start <= 0;

    while (board.pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending_colors.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
